// ===== sv/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 text validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  // byte counter sizing
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CntW       = CountWidth + 1;
  localparam int unsigned CmpW       = (CntW > 16) ? CntW : 16;
  localparam int unsigned CapInt     = (CountWidth >= 16) ? 65535 : ((1 << CountWidth) - 1);
  localparam logic [CntW-1:0] CountLimit = CntW'(1) << CountWidth;
  localparam logic [CmpW-1:0] CountCap   = CmpW'(CapInt);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgAllowEmpty  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdentityMode = 2'd2;

  // sequence lengths
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // code point limits
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpMin4     = 21'h010000;
  localparam logic [20:0] CpSurrLo   = 21'h00D800;
  localparam logic [20:0] CpSurrHi   = 21'h00DFFF;
  localparam logic [20:0] CpMax      = 21'h10FFFF;

  // special bytes
  localparam logic [7:0] ByteTab  = 8'h09;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteDel  = 8'h7F;
  localparam logic [7:0] ByteSpace = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    logic        string_valid;
    logic [15:0] byte_count;
  } out_item_t;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  pend;
    logic [2:0]  seq_len;
    logic [20:0] acc;
    logic        err;
  } seq_state_t;

  localparam seq_state_t SeqClear = '{pend: 2'd0, seq_len: SeqNone, acc: 21'd0, err: 1'b0};

endpackage

// ===== sv/utf8v_decode.sv =====
// ----------------------------------------------------------------------------
// utf8v_decode
// One-byte step of the UTF-8 sequence checker (combinational).
// ----------------------------------------------------------------------------
module utf8v_decode (
  input  utf8v_pkg::seq_state_t cur_i,
  input  logic [7:0]            byte_i,
  input  logic                  identity_mode_i,
  output utf8v_pkg::seq_state_t nxt_o
);
  import utf8v_pkg::*;

  logic        ctrl_bad;
  logic [20:0] acc_sh;
  seq_state_t  failed;

  assign failed = '{pend: 2'd0, seq_len: SeqNone, acc: 21'd0, err: 1'b1};
  assign acc_sh = {cur_i.acc[14:0], byte_i[5:0]};

  always_comb begin
    if (byte_i == ByteDel) begin
      ctrl_bad = 1'b1;
    end else if (byte_i >= ByteSpace) begin
      ctrl_bad = 1'b0;
    end else if (identity_mode_i) begin
      ctrl_bad = 1'b1;
    end else begin
      ctrl_bad = !(byte_i == ByteTab || byte_i == ByteLf || byte_i == ByteCr);
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.err) begin
      nxt_o = cur_i;
    end else if (cur_i.pend != 2'd0) begin
      if (byte_i[7:6] != 2'b10) begin
        nxt_o = failed;
      end else begin
        nxt_o.acc  = acc_sh;
        nxt_o.pend = cur_i.pend - 2'd1;
        if (cur_i.pend == 2'd1) begin
          if ((cur_i.seq_len == SeqLen3 && acc_sh < CpMin3) ||
              (cur_i.seq_len == SeqLen4 && acc_sh < CpMin4) ||
              (acc_sh >= CpSurrLo && acc_sh <= CpSurrHi) ||
              acc_sh > CpMax) begin
            nxt_o = failed;
          end else begin
            nxt_o.seq_len = SeqNone;
            nxt_o.acc     = 21'd0;
          end
        end
      end
    end else if (ctrl_bad) begin
      nxt_o = failed;
    end else if (!byte_i[7]) begin
      nxt_o = cur_i;
    end else if (byte_i[7:5] == 3'b110) begin
      // c0 and c1 leads are always overlong
      if (byte_i[4:1] == 4'd0) begin
        nxt_o = failed;
      end else begin
        nxt_o.seq_len = SeqLen2;
        nxt_o.pend    = 2'd1;
        nxt_o.acc     = {16'd0, byte_i[4:0]};
      end
    end else if (byte_i[7:4] == 4'b1110) begin
      nxt_o.seq_len = SeqLen3;
      nxt_o.pend    = 2'd2;
      nxt_o.acc     = {17'd0, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      nxt_o.seq_len = SeqLen4;
      nxt_o.pend    = 2'd3;
      nxt_o.acc     = {18'd0, byte_i[2:0]};
    end else begin
      nxt_o = failed;
    end
  end

endmodule

// ===== sv/utf8_text_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_text_validator
// Checks strings one byte per item and gives one verdict per string.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+-------------------------
//   input     | in        | in_valid_i/in_ready_o  | in_item_i (byte, eos, empty)
//   result    | out       | out_valid_o/out_ready_i| out_item_o (valid, count)
//   config    | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one byte per cycle while input ready is high, through the decode step; an
// item's verdict, if any, is registered into the output register, or into the
// skid entry if the output register holds one not yet taken. the two-entry
// result buffer keeps input ready free of the result handshake; input ready
// drops only when both entries hold verdicts. reset clears all string state
// and loads the register defaults; config writes are always taken.
// ----------------------------------------------------------------------------
module utf8_text_validator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  utf8v_pkg::in_item_t      in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output utf8v_pkg::out_item_t     out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [utf8v_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]              cfg_data_i
);
  import utf8v_pkg::*;

  // configuration registers
  logic        allow_empty_q;
  logic [15:0] max_len_q;
  logic        identity_q;

  // string state
  seq_state_t      seq_q, seq_step, seq_d;
  logic [CntW-1:0] cnt_q, cnt_step, cnt_d;

  // result buffer
  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;

  logic in_acc, push, pop, res_ok;
  logic [CmpW-1:0] cnt_ext, max_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign pop         = out_valid_q && out_ready_i;
  assign push        = in_acc && (in_item_i.end_of_string || in_item_i.empty_string);

  utf8v_decode u_decode (
    .cur_i           (seq_q),
    .byte_i          (in_item_i.data_byte),
    .identity_mode_i (identity_q),
    .nxt_o           (seq_step)
  );

  // count saturates one past the largest showable length
  assign cnt_step = (cnt_q < CountLimit) ? cnt_q + CntW'(1) : cnt_q;
  assign cnt_ext  = CmpW'(cnt_step);
  assign max_ext  = CmpW'(max_len_q);

  // verdict for the item at the input
  always_comb begin
    res_ok = !seq_step.err && seq_step.pend == 2'd0 && cnt_ext <= max_ext &&
             (cnt_ext != '0 || allow_empty_q);
    if (in_item_i.empty_string) begin
      res.string_valid = allow_empty_q;
      res.byte_count   = 16'd0;
    end else begin
      res.string_valid = res_ok;
      res.byte_count   = (cnt_ext > CountCap) ? 16'(CountCap) : 16'(cnt_ext);
    end
  end

  // next string state: cleared after every verdict
  always_comb begin
    seq_d = seq_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      if (in_item_i.empty_string || in_item_i.end_of_string) begin
        seq_d = SeqClear;
        cnt_d = '0;
      end else begin
        seq_d = seq_step;
        cnt_d = cnt_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SeqClear;
      cnt_q <= '0;
    end else begin
      seq_q <= seq_d;
      cnt_q <= cnt_d;
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_empty_q <= 1'b0;
      max_len_q     <= 16'hFFFF;
      identity_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgAllowEmpty:   allow_empty_q <= cfg_data_i[0];
        CfgMaxLength:    max_len_q     <= cfg_data_i;
        CfgIdentityMode: identity_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // result buffer: output register backed by one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

// ===== sv/utf8v_checker.sv =====
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level assertions for the UTF-8 text validator, bound to the top level.
// ----------------------------------------------------------------------------
module utf8v_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input utf8v_pkg::in_item_t      in_item_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input utf8v_pkg::out_item_t     out_item_o
);
  import utf8v_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // input stalls only with a full result buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // empty string into an idle output gives a zero-length verdict next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.empty_string && !out_valid_o
    |=> out_valid_o && out_item_o.byte_count == 16'd0)
    else $error("empty string verdict missing");

  // mid-string byte into an idle output gives no verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_item_i.empty_string &&
    !in_item_i.end_of_string && !out_valid_o
    |=> !out_valid_o)
    else $error("verdict without end of string");

endmodule

bind utf8_text_validator utf8v_checker u_utf8v_checker (.*);

// ===== test/tb_utf8_text_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_text_validator
// Self-checking bench for the UTF-8 text validator. A short table of corner
// strings runs first. Random well-formed and broken strings follow under
// several register settings. Both channels idle and stall at random, and
// every verdict is compared field by field with a typed table entry or with
// a behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_utf8_text_validator;
  import utf8v_pkg::*;

  // how a directed row is checked: by the decoder below or by a typed verdict
  typedef enum logic {ChkModel = 1'b0, ChkTyped = 1'b1} chk_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        empty;
    chk_e        chk;
    logic        ok;
    logic [15:0] count;
  } dir_row_t;

  // kinds of damage applied to a random string
  typedef enum int {
    FlawNone, FlawByte, FlawTruncate, FlawControl, FlawStray, FlawOverlong,
    FlawSurrogate, FlawAboveMax, FlawBadLead, FlawNoise
  } flaw_e;

  // corner strings at reset settings (empty refused, no length limit, identity off)
  localparam int DirRows = 27;
  localparam dir_row_t DirTable [DirRows] = '{
    '{8'hA5, 1'b1, 1'b1, ChkTyped, 1'b0, 16'd0},  // empty string refused
    '{8'h41, 1'b1, 1'b0, ChkTyped, 1'b1, 16'd1},  // plain ascii
    '{8'h00, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd1},  // nul
    '{8'h7F, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd1},  // del
    '{8'h09, 1'b1, 1'b0, ChkTyped, 1'b1, 16'd1},  // tab allowed outside identity mode
    '{8'h80, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd1},  // stray continuation
    '{8'hC1, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // overlong two-byte lead,
    '{8'hBF, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd2},  //   then only counting
    '{8'hE0, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // three-byte form below U+0800
    '{8'h9F, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'hBF, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd3},
    '{8'hED, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // surrogate U+D800
    '{8'hA0, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd3},
    '{8'hF4, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // U+110000, above the top
    '{8'h90, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'h80, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd4},
    '{8'hF5, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // f5 lead fails once complete
    '{8'h80, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'h80, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},
    '{8'h80, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd4},
    '{8'hFF, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd1},  // f8..ff lead fails at once
    '{8'hE2, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // truncated at string end
    '{8'h82, 1'b1, 1'b0, ChkTyped, 1'b0, 16'd2},
    '{8'h61, 1'b0, 1'b0, ChkModel, 1'b0, 16'd0},  // partial string dropped by
    '{8'h00, 1'b0, 1'b1, ChkTyped, 1'b0, 16'd0}   //   an empty item
  };

  logic                clk;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [15:0]         cfg_data;

  // typed verdict that travels with a directed item
  chk_e                item_chk;
  out_item_t           item_typed;

  // register copies seen by the decoder
  logic                cur_allow_empty;
  logic [15:0]         cur_max_length;
  logic                cur_identity;

  // decoder state of the string in flight
  logic [1:0]          dec_pend;
  logic [2:0]          dec_seq;
  logic [20:0]         dec_cp;
  logic                dec_bad;
  logic [CntW-1:0]     str_len;

  out_item_t           pending_verdicts [$];
  logic [7:0]          str_bytes [$];
  bit                  gaps_on;

  int                  verdict_errors;
  int                  n_verdicts;
  int                  n_passed;
  int                  n_bytes;
  int                  n_reg_writes;

  utf8_text_validator dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // behavioral decoder
  // --------------------------------------------------------------------------

  // nul, del and control bytes; tab, lf and cr only pass outside identity mode
  function automatic logic ctrl_refused(input logic [7:0] b);
    if (b == ByteDel) return 1'b1;
    if (b >= ByteSpace) return 1'b0;
    return cur_identity || !(b == ByteTab || b == ByteLf || b == ByteCr);
  endfunction

  // a failed check: forget the sequence, keep counting
  task automatic drop_sequence();
    dec_bad  = 1'b1;
    dec_pend = 2'd0;
    dec_seq  = SeqNone;
    dec_cp   = '0;
  endtask

  task automatic clear_string();
    dec_pend = 2'd0;
    dec_seq  = SeqNone;
    dec_cp   = '0;
    dec_bad  = 1'b0;
    str_len  = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    // the length saturates one past the counter's range
    if (str_len < CountLimit) str_len = str_len + 1'b1;
    if (!dec_bad) begin
      if (dec_pend != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          drop_sequence();
        end else begin
          dec_cp   = {dec_cp[14:0], b[5:0]};
          dec_pend = dec_pend - 2'd1;
          if (dec_pend == 2'd0) begin
            // sequence complete: overlong, surrogate and range checks
            if ((dec_seq == SeqLen3 && dec_cp < CpMin3) ||
                (dec_seq == SeqLen4 && dec_cp < CpMin4) ||
                (dec_cp >= CpSurrLo && dec_cp <= CpSurrHi) ||
                dec_cp > CpMax) begin
              drop_sequence();
            end else begin
              dec_seq = SeqNone;
              dec_cp  = '0;
            end
          end
        end
      end else if (ctrl_refused(b)) begin
        drop_sequence();
      end else if (b[7:5] == 3'b110) begin
        // c0 and c1 can only be overlong
        if (b[4:1] == 4'd0) begin
          drop_sequence();
        end else begin
          dec_seq  = SeqLen2;
          dec_pend = 2'd1;
          dec_cp   = {16'd0, b[4:0]};
        end
      end else if (b[7:4] == 4'b1110) begin
        dec_seq  = SeqLen3;
        dec_pend = 2'd2;
        dec_cp   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        dec_seq  = SeqLen4;
        dec_pend = 2'd3;
        dec_cp   = {18'd0, b[2:0]};
      end else if (b[7]) begin
        // stray continuation or f8..ff lead
        drop_sequence();
      end
    end
  endtask

  // one accepted item in, at most one verdict out
  task automatic judge_item(input in_item_t it, output bit has, output out_item_t v);
    has = 1'b0;
    v   = '0;
    if (it.empty_string) begin
      // drops any partial string and answers for an empty one
      clear_string();
      has            = 1'b1;
      v.string_valid = cur_allow_empty;
    end else begin
      take_byte(it.data_byte);
      if (it.end_of_string) begin
        has            = 1'b1;
        v.string_valid = !dec_bad && dec_pend == 2'd0 && str_len <= cur_max_length &&
                         (str_len != '0 || cur_allow_empty);
        if (CmpW'(str_len) > CountCap) v.byte_count = 16'(CountCap);
        else v.byte_count = 16'(str_len);
        clear_string();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // scoreboard: register writes, accepted items and verdicts, all sampled at
  // the rising edge so the decoder sees items in acceptance order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    bit        has;
    out_item_t v;
    out_item_t want;
    if (!rst_ni) begin
      cur_allow_empty = 1'b0;
      cur_max_length  = 16'hFFFF;
      cur_identity    = 1'b0;
      clear_string();
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_reg_writes++;
        case (cfg_index)
          CfgAllowEmpty:   cur_allow_empty = cfg_data[0];
          CfgMaxLength:    cur_max_length  = cfg_data;
          CfgIdentityMode: cur_identity    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        judge_item(in_item, has, v);
        if (!in_item.empty_string) n_bytes++;
        if (has) begin
          if (item_chk == ChkTyped) v = item_typed;
          pending_verdicts.insert(pending_verdicts.size(), v);
        end
      end
      if (out_valid && out_ready) begin
        n_verdicts++;
        if (out_item.string_valid === 1'b1) n_passed++;
        if (pending_verdicts.size() == 0) begin
          verdict_errors++;
          if (verdict_errors <= 10)
            $display("%0t: verdict with none expected: valid %b count %0d",
                     $realtime, out_item.string_valid, out_item.byte_count);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_item.string_valid !== want.string_valid ||
              out_item.byte_count !== want.byte_count) begin
            verdict_errors++;
            if (verdict_errors <= 10)
              $display("%0t: verdict %0d: valid exp %b got %b, count exp %0d got %0d",
                       $realtime, n_verdicts, want.string_valid, out_item.string_valid,
                       want.byte_count, out_item.byte_count);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, mostly short, a few long, with stretches of
  // steady ready in between
  // --------------------------------------------------------------------------
  function automatic int stall_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  initial begin : result_side
    int r;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        out_ready = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat (stall_cycles()) @(negedge clk);
        out_ready = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called and returns at a falling edge; valid stays up after acceptance so
  // back-to-back items need no extra assignment
  task automatic send_item(input logic [7:0] data, input logic eos, input logic empty,
                           input chk_e chk = ChkModel, input out_item_t typed = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_item    = '{data_byte: data, end_of_string: eos, empty_string: empty};
    item_chk   = chk;
    item_typed = typed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender holds off until every verdict has come back
  task automatic drain_verdicts();
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    drain_verdicts();
    // leave a little slack after the last verdict
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one-bit registers get random upper data bits, which must be ignored
  task automatic set_regs(input logic allow, input logic [15:0] limit, input logic ident);
    write_reg(CfgAllowEmpty, {15'($urandom), allow});
    write_reg(CfgMaxLength, limit);
    write_reg(CfgIdentityMode, {15'($urandom), ident});
  endtask

  // append one byte to the string being built
  task automatic add_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  // utf-8 encoding of cp in len bytes; a longer len than needed gives an
  // overlong form
  task automatic push_cp(input logic [20:0] cp, input int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic push_good_char();
    int          r;
    logic [20:0] cp;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      push_cp(21'($urandom_range(32, 126)), 1);
    end else if (r < 48) begin
      case ($urandom_range(0, 2))
        0:       add_byte(ByteTab);
        1:       add_byte(ByteLf);
        default: add_byte(ByteCr);
      endcase
    end else if (r < 63) begin
      push_cp(21'($urandom_range('h80, 'h7FF)), 2);
    end else if (r < 83) begin
      // skip the surrogate block
      cp = 21'($urandom_range('h800, 'hF7FF));
      if (cp >= CpSurrLo) cp = cp + 21'h800;
      push_cp(cp, 3);
    end else begin
      push_cp(21'($urandom_range('h10000, 'h10FFFF)), 4);
    end
  endtask

  task automatic push_bad_char(input flaw_e flaw);
    case (flaw)
      FlawControl: begin
        if ($urandom_range(0, 3) == 0) add_byte(ByteDel);
        else add_byte(8'($urandom_range(0, 31)));
      end
      FlawStray:     add_byte(8'($urandom_range('h80, 'hBF)));
      FlawOverlong: begin
        case ($urandom_range(0, 2))
          0:       push_cp(21'($urandom_range(0, 'h7F)), 2);
          1:       push_cp(21'($urandom_range(0, 'h7FF)), 3);
          default: push_cp(21'($urandom_range(0, 'hFFFF)), 4);
        endcase
      end
      FlawSurrogate: push_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
      FlawAboveMax:  push_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      FlawBadLead:   add_byte(8'($urandom_range('hF8, 'hFF)));
      default:       push_good_char();
    endcase
  endtask

  // mostly well-formed strings with random content; about a third broken
  task automatic build_string();
    int    r;
    int    nchars;
    int    spot;
    flaw_e flaw;
    str_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 8) nchars = 0;
    else if (r < 85) nchars = $urandom_range(1, 6);
    else nchars = $urandom_range(7, 14);
    r = $urandom_range(0, 99);
    flaw = (r < 68) ? FlawNone : flaw_e'($urandom_range(FlawByte, FlawNoise));
    if (flaw != FlawNone && nchars == 0) nchars = 1;
    spot = (nchars > 0) ? $urandom_range(0, nchars - 1) : 0;
    for (int i = 0; i < nchars; i++) begin
      if (i == spot) push_bad_char(flaw);
      else push_good_char();
    end
    case (flaw)
      FlawByte:     str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom);
      FlawTruncate: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
      FlawNoise: begin
        str_bytes.delete();
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int n_items, input bit pause_mid);
    int sent;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      build_string();
      // about one string in four goes through with no input gaps
      gaps_on = ($urandom_range(0, 3) != 0);
      if (str_bytes.size() == 0) begin
        // empty string; byte and end mark are don't-cares here
        send_item(8'($urandom), 1'($urandom), 1'b1);
        sent += 1;
      end else if ($urandom_range(0, 99) < 5) begin
        // partial string cut off by an empty item
        foreach (str_bytes[i]) send_item(str_bytes[i], 1'b0, 1'b0);
        send_item(8'($urandom), 1'($urandom), 1'b1);
        sent += str_bytes.size() + 1;
      end else begin
        foreach (str_bytes[i]) send_item(str_bytes[i], i == str_bytes.size() - 1, 1'b0);
        sent += str_bytes.size();
      end
      if (pause_mid && !paused && sent >= n_items / 2) begin
        drain_verdicts();
        paused = 1'b1;
      end
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    item_chk       = ChkModel;
    item_typed     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CfgAllowEmpty;
    cfg_data       = '0;
    gaps_on        = 1'b1;
    verdict_errors = 0;
    n_verdicts     = 0;
    n_passed       = 0;
    n_bytes        = 0;
    n_reg_writes   = 0;
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // corner strings at reset settings
    for (int i = 0; i < DirRows; i++)
      send_item(DirTable[i].data, DirTable[i].eos, DirTable[i].empty, DirTable[i].chk,
                '{string_valid: DirTable[i].ok, byte_count: DirTable[i].count});

    // random strings at reset settings, then the other extremes
    run_random(150, 1'b0);
    set_regs(1'b1, 16'd0, 1'b1);
    run_random(60, 1'b0);
    set_regs(1'b0, 16'd5, 1'b0);
    run_random(110, 1'b0);

    // registers changed mid-string: the lf before the change passes, the tab
    // after it fails in identity mode; the new limit applies at the verdict
    send_item(8'h61, 1'b0, 1'b0);
    send_item(ByteLf, 1'b0, 1'b0);
    write_reg(CfgIdentityMode, 16'd1);
    write_reg(CfgMaxLength, 16'd3);
    send_item(ByteTab, 1'b1, 1'b0);

    // no limit, empty allowed; the sender stops once halfway for a full drain
    set_regs(1'b1, 16'hFFFF, 1'b0);
    run_random(130, 1'b1);

    set_regs(1'b0, 16'($urandom_range(8, 24)), 1'b1);
    run_random(120, 1'b0);
    set_regs(1'b1, 16'($urandom), 1'b0);
    run_random(80, 1'b0);

    drain_verdicts();
    repeat (10) @(negedge clk);
    $display("%0d verdicts (%0d valid) over %0d bytes, %0d register writes, %0d errors",
             n_verdicts, n_passed, n_bytes, n_reg_writes, verdict_errors);
    $display("covered corner strings, random strings in all register extremes and "
             , "mid-string register changes");
    if (verdict_errors == 0 && pending_verdicts.size() == 0) begin
      $display("utf8_text_validator test passed");
    end else begin
      $display("utf8_text_validator test failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("utf8_text_validator test failed");
    $finish;
  end

endmodule
